// ===== design/patch_tile_splitter_top_assert.svh =====
// assertion macros shared by the checker
`ifndef PATCH_TILE_SPLITTER_TOP_ASSERT_SVH
`define PATCH_TILE_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PTS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pts checker: same-cycle property failed");

// next-cycle implication, disabled while reset is low
`define PTS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pts checker: next-cycle property failed");

`endif

// ===== design/pts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int MAX_TILES  = 64;
    localparam int POS_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = POS_W + 1;
    localparam int CAP_W      = $clog2(MAX_TILES) + 1;
    localparam int NUM_W      = $clog2(MAX_TILES);
    localparam int TOT_W      = 2 * POS_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(POS_W + 1);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_FIELD_COLS    = 2'd0;
    localparam cfg_idx_t CFG_FIELD_ROWS    = 2'd1;
    localparam cfg_idx_t CFG_TILE_CAPACITY = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] patch_x0;
        logic [POS_W-1:0] patch_y0;
        logic [DIM_W-1:0] patch_cols;
        logic [DIM_W-1:0] patch_rows;
        logic [DIM_W-1:0] tile_cols_req;
        logic [DIM_W-1:0] tile_rows_req;
    } patch_in_t;

    typedef struct packed {
        logic             tile_valid;
        logic [POS_W-1:0] tile_x;
        logic [POS_W-1:0] tile_y;
        logic [DIM_W-1:0] tile_cols;
        logic [DIM_W-1:0] tile_rows;
        logic             covers_full_rows;
        logic             is_full_field;
        logic             touches_edge;
        logic [NUM_W-1:0] tile_number;
        logic [TOT_W-1:0] total_tiles;
        logic             last;
    } tile_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_COLS,
        ST_DIV_ROWS,
        ST_MUL,
        ST_SIZE,
        ST_EMIT,
        ST_SINGLE
    } state_t;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic div_rows;
        logic store_across;
        logic store_down;
        logic mul;
        logic size;
        logic load_tile;
        logic load_single;
    } ctrl_cmd_t;

    typedef struct packed {
        logic patch_ok;
        logic div_done;
        logic emit_zero;
        logic tile_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== design/pts_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pts_div (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [pts_pkg::POS_W-1:0] dividend,
    input  wire logic [pts_pkg::DIM_W-1:0] divisor,
    output logic                         done,
    output logic [pts_pkg::POS_W-1:0]    quotient
);
    import pts_pkg::*;

    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic                 done_reg, done_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [POS_W-1:0]     quo_reg, quo_next;
    logic [DIM_W-1:0]     dsr_reg, dsr_next;
    logic [DIM_W:0]       shifted;
    logic                 fits;

    // one restoring step per cycle
    always_comb begin
        shifted    = {rem_reg, quo_reg[POS_W-1]};
        fits       = shifted >= {1'b0, dsr_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        if (start) begin
            count_next = DIV_CNT_W'(POS_W);
            rem_next   = '0;
            quo_next   = dividend;
            dsr_next   = divisor;
        end else if (count_reg != '0) begin
            rem_next   = fits ? DIM_W'(shifted - {1'b0, dsr_reg}) : shifted[DIM_W-1:0];
            quo_next   = {quo_reg[POS_W-2:0], fits};
            count_next = count_reg - DIV_CNT_W'(1);
            done_next  = (count_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/pts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pts_datapath (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire pts_pkg::ctrl_cmd_t         cmd,
    output pts_pkg::dp_status_t             status,
    input  wire logic                       cfg_valid,
    input  wire pts_pkg::cfg_idx_t          cfg_index,
    input  wire logic [pts_pkg::DIM_W-1:0]  cfg_data,
    input  wire pts_pkg::patch_in_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output pts_pkg::tile_out_t              m_data
);
    import pts_pkg::*;

    logic [DIM_W-1:0] field_cols_reg, field_cols_next;
    logic [DIM_W-1:0] field_rows_reg, field_rows_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             m_valid_reg, m_valid_next;

    patch_in_t        patch_reg;
    logic [DIM_W-1:0] tw_reg, th_reg;
    logic [DIM_W-1:0] across_reg, down_reg;
    logic [TOT_W-1:0] total_reg;
    logic [CAP_W-1:0] emit_reg;
    logic [DIM_W-1:0] off_col_reg, off_row_reg;
    logic [NUM_W-1:0] num_reg;
    tile_out_t        m_data_reg, m_data_next;

    logic [DIM_W-1:0] cfg_dim;
    logic             patch_ok;
    logic [DIM_W-1:0] tw_eff, th_eff;
    logic [POS_W-1:0] div_dividend;
    logic [DIM_W-1:0] div_divisor;
    logic             div_done;
    logic [POS_W-1:0] div_quo;
    logic [DIM_W-1:0] quo_plus;
    logic [TOT_W-1:0] prod;
    logic [CAP_W-1:0] cap_eff, emit_next;
    logic             out_free;
    logic [DIM_W-1:0] w_rem, h_rem, w_clip, h_clip;
    logic [DIM_W-1:0] x_full, y_full, x_end, y_end;
    logic [DIM_W:0]   col_adv, row_adv;
    logic             full_rows;

    // configuration, dimensions saturate at the field limit
    always_comb begin
        cfg_dim         = (cfg_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;
        field_cols_next = field_cols_reg;
        field_rows_next = field_rows_reg;
        cap_next        = cap_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_FIELD_COLS:    field_cols_next = cfg_dim;
                CFG_FIELD_ROWS:    field_rows_next = cfg_dim;
                CFG_TILE_CAPACITY: cap_next = cfg_data[CAP_W-1:0];
                default:           cap_next = cap_reg;
            endcase
        end
    end

    always_comb begin
        patch_ok = (field_cols_reg != '0) && (field_rows_reg != '0) &&
                   (patch_reg.patch_cols != '0) && (patch_reg.patch_rows != '0) &&
                   ({1'b0, patch_reg.patch_x0} < field_cols_reg) &&
                   ({1'b0, patch_reg.patch_y0} < field_rows_reg) &&
                   (patch_reg.patch_cols <= field_cols_reg - {1'b0, patch_reg.patch_x0}) &&
                   (patch_reg.patch_rows <= field_rows_reg - {1'b0, patch_reg.patch_y0});
        tw_eff = (patch_reg.tile_cols_req == '0 ||
                  patch_reg.tile_cols_req > patch_reg.patch_cols) ?
                 patch_reg.patch_cols : patch_reg.tile_cols_req;
        th_eff = (patch_reg.tile_rows_req == '0 ||
                  patch_reg.tile_rows_req > patch_reg.patch_rows) ?
                 patch_reg.patch_rows : patch_reg.tile_rows_req;
    end

    // ceil(n / t) as floor((n - 1) / t) + 1
    assign div_dividend = cmd.div_rows ? POS_W'(patch_reg.patch_rows - DIM_W'(1))
                                       : POS_W'(patch_reg.patch_cols - DIM_W'(1));
    assign div_divisor  = cmd.div_rows ? th_eff : tw_eff;
    assign quo_plus     = {1'b0, div_quo} + DIM_W'(1);

    pts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // both factors are at most MAX_DIM, so the product fits the total width
    assign prod      = TOT_W'(across_reg) * TOT_W'(down_reg);
    assign cap_eff   = (cap_reg > CAP_W'(MAX_TILES)) ? CAP_W'(MAX_TILES) : cap_reg;
    assign emit_next = (total_reg < TOT_W'(cap_eff)) ? total_reg[CAP_W-1:0] : cap_eff;
    assign out_free  = !m_valid_reg || m_ready;

    // current tile geometry and flags
    always_comb begin
        w_rem     = patch_reg.patch_cols - off_col_reg;
        h_rem     = patch_reg.patch_rows - off_row_reg;
        w_clip    = (w_rem > tw_reg) ? tw_reg : w_rem;
        h_clip    = (h_rem > th_reg) ? th_reg : h_rem;
        x_full    = {1'b0, patch_reg.patch_x0} + off_col_reg;
        y_full    = {1'b0, patch_reg.patch_y0} + off_row_reg;
        x_end     = x_full + w_clip;
        y_end     = y_full + h_clip;
        col_adv   = {1'b0, off_col_reg} + {1'b0, tw_reg};
        row_adv   = {1'b0, off_row_reg} + {1'b0, th_reg};
        full_rows = (x_full == '0) && (w_clip == field_cols_reg);

        m_data_next = m_data_reg;
        if (cmd.load_tile) begin
            m_data_next.tile_valid       = 1'b1;
            m_data_next.tile_x           = x_full[POS_W-1:0];
            m_data_next.tile_y           = y_full[POS_W-1:0];
            m_data_next.tile_cols        = w_clip;
            m_data_next.tile_rows        = h_clip;
            m_data_next.covers_full_rows = full_rows;
            m_data_next.is_full_field    = full_rows && (y_full == '0) &&
                                           (h_clip == field_rows_reg);
            m_data_next.touches_edge     = (x_full == '0) || (y_full == '0) ||
                                           (x_end == field_cols_reg) ||
                                           (y_end == field_rows_reg);
            m_data_next.tile_number      = num_reg;
            m_data_next.total_tiles      = total_reg;
            m_data_next.last             = (CAP_W'(num_reg) + CAP_W'(1) == emit_reg);
        end else if (cmd.load_single) begin
            m_data_next             = '0;
            m_data_next.total_tiles = patch_ok ? total_reg : '0;
            m_data_next.last        = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_tile || cmd.load_single) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_cols_reg <= DIM_W'(MAX_DIM);
            field_rows_reg <= DIM_W'(MAX_DIM);
            cap_reg        <= CAP_W'(MAX_TILES);
            m_valid_reg    <= 1'b0;
        end else begin
            field_cols_reg <= field_cols_next;
            field_rows_reg <= field_rows_next;
            cap_reg        <= cap_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            patch_reg <= s_data;
        end
        if (cmd.div_start) begin
            tw_reg <= tw_eff;
            th_reg <= th_eff;
        end
        if (cmd.store_across) begin
            across_reg <= quo_plus;
        end
        if (cmd.store_down) begin
            down_reg <= quo_plus;
        end
        if (cmd.mul) begin
            total_reg <= prod;
        end
        if (cmd.size) begin
            emit_reg    <= emit_next;
            off_col_reg <= '0;
            off_row_reg <= '0;
            num_reg     <= '0;
        end else if (cmd.load_tile) begin
            num_reg <= num_reg + NUM_W'(1);
            if (col_adv >= {1'b0, patch_reg.patch_cols}) begin
                off_col_reg <= '0;
                off_row_reg <= row_adv[DIM_W-1:0];
            end else begin
                off_col_reg <= col_adv[DIM_W-1:0];
            end
        end
        m_data_reg <= m_data_next;
    end

    assign status.patch_ok  = patch_ok;
    assign status.div_done  = div_done;
    assign status.emit_zero = (emit_next == '0);
    assign status.tile_last = (CAP_W'(num_reg) + CAP_W'(1) == emit_reg);
    assign status.out_free  = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== design/pts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pts_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pts_pkg::dp_status_t status,
    output pts_pkg::ctrl_cmd_t       cmd
);
    import pts_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_PREP;
            ST_PREP:     state_next = status.patch_ok ? ST_DIV_COLS : ST_SINGLE;
            ST_DIV_COLS: if (status.div_done) state_next = ST_DIV_ROWS;
            ST_DIV_ROWS: if (status.div_done) state_next = ST_MUL;
            ST_MUL:      state_next = ST_SIZE;
            ST_SIZE:     state_next = status.emit_zero ? ST_SINGLE : ST_EMIT;
            ST_EMIT: begin
                if (status.out_free && status.tile_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE:   if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_PREP: begin
                cmd.div_start = status.patch_ok;
            end
            ST_DIV_COLS: begin
                cmd.store_across = status.div_done;
                cmd.div_start    = status.div_done;
                cmd.div_rows     = 1'b1;
            end
            ST_DIV_ROWS: begin
                cmd.store_down = status.div_done;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_SIZE: begin
                cmd.size = 1'b1;
            end
            ST_EMIT: begin
                cmd.load_tile = status.out_free;
            end
            ST_SINGLE: begin
                cmd.load_single = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/patch_tile_splitter_top.sv =====
// patch tile splitter: takes one patch request (corner, size, wanted tile size), checks it
// against the configured field and walks it in row-major tile order, one result per tile,
// edge tiles clipped, up to tile_capacity (max 64) results, each with the full tile count.
// an invalid patch or a zero capacity gives a single result with tile_valid low and last high.
// one request is in work at a time: setup is one capture, one check, two 12-step ceiling
// divisions on a shared divider, one multiply and one sizing step, then one tile per cycle
// while the result side keeps taking them; an invalid patch goes from the check straight to
// its single result. the next request is taken once the last result of the current one sits
// in the output register. configuration must be written only idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none

module patch_tile_splitter_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // patch requests
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire pts_pkg::patch_in_t        s_data,
    // tile results
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output pts_pkg::tile_out_t             m_data,
    // register writes: 0 field_cols, 1 field_rows, 2 tile_capacity
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire pts_pkg::cfg_idx_t         cfg_index,
    input  wire logic [pts_pkg::DIM_W-1:0] cfg_data
);
    import pts_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // register writes are always accepted and go straight into the configuration registers
    assign cfg_ready = 1'b1;

    // sequencer: capture, check, divide, multiply, size, then the tile walk or a single result
    pts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // field registers, tile counts, walk offsets and the output register
    pts_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== design/pts_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "patch_tile_splitter_top_assert.svh"

module pts_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pts_pkg::tile_out_t m_data
);
    import pts_pkg::*;

    // a stalled result holds
    `PTS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // a count-only result stands alone
    `PTS_ASSERT_SAME(a_single_last, aclk, aresetn, m_valid && !m_data.tile_valid, m_data.last && (m_data.tile_number == '0))

    // an emitted tile is never empty and belongs to a counted patch
    `PTS_ASSERT_SAME(a_tile_nonempty, aclk, aresetn, m_valid && m_data.tile_valid, (m_data.tile_cols != '0) && (m_data.tile_rows != '0) && (m_data.total_tiles != '0))

    // one request at a time
    `PTS_ASSERT_NEXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind patch_tile_splitter_top pts_checker u_pts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
